// ----- hdl/ylss_pkg.sv -----
// ----------------------------------------------------------------------------
// ylss_pkg
// Shared types, constants and calendar helpers of the yearly lamp schedule
// switch.
// ----------------------------------------------------------------------------
package ylss_pkg;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdEval  = 1'b1;

  localparam logic [1:0] CfgEnable     = 2'd0;
  localparam logic [1:0] CfgStartMonth = 2'd1;
  localparam logic [1:0] CfgStartDay   = 2'd2;
  localparam logic [1:0] CfgTotalDays  = 2'd3;

  localparam int unsigned YearDays   = 366;
  localparam int unsigned HourMax    = 23;
  localparam int unsigned MinuteMax  = 59;
  localparam int unsigned MinPerHour = 60;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
  } clock_t;

  // day number of the day before the first of the month, months 1..12
  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] res;
    unique case (month)
      4'd1:    res = 9'd0;
      4'd2:    res = 9'd31;
      4'd3:    res = 9'd60;
      4'd4:    res = 9'd91;
      4'd5:    res = 9'd121;
      4'd6:    res = 9'd152;
      4'd7:    res = 9'd182;
      4'd8:    res = 9'd213;
      4'd9:    res = 9'd244;
      4'd10:   res = 9'd274;
      4'd11:   res = 9'd305;
      4'd12:   res = 9'd335;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // month length with a 29-day february, 0 for a bad month
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] res;
    unique case (month)
      4'd2:                             res = 5'd29;
      4'd4, 4'd6, 4'd9, 4'd11:          res = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                     res = 5'd31;
      default:                          res = 5'd0;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] bcd_byte(input logic [7:0] b);
    return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
  endfunction

endpackage

// ----- hdl/ylss_decide.sv -----
// ----------------------------------------------------------------------------
// ylss_decide
// Decodes the BCD on and off times of one table entry and decides the lamp
// state for the current time, with a window that may wrap past midnight.
// ----------------------------------------------------------------------------
module ylss_decide (
  input  logic [31:0]          entry_i,
  input  ylss_pkg::clock_t     now_i,
  output logic                 lamp_o
);

  logic [7:0]  on_h, on_m, off_h, off_m;
  logic [10:0] on_g, off_g, now_g;
  logic        bad_time;

  always_comb begin
    on_h  = ylss_pkg::bcd_byte(entry_i[31:24]);
    on_m  = ylss_pkg::bcd_byte(entry_i[23:16]);
    off_h = ylss_pkg::bcd_byte(entry_i[15:8]);
    off_m = ylss_pkg::bcd_byte(entry_i[7:0]);

    bad_time = (on_h > 8'(ylss_pkg::HourMax)) || (on_m > 8'(ylss_pkg::MinuteMax)) ||
               (off_h > 8'(ylss_pkg::HourMax)) || (off_m > 8'(ylss_pkg::MinuteMax));

    on_g  = 11'(on_h) * 11'(ylss_pkg::MinPerHour) + 11'(on_m);
    off_g = 11'(off_h) * 11'(ylss_pkg::MinPerHour) + 11'(off_m);
    now_g = 11'(now_i.hour) * 11'(ylss_pkg::MinPerHour) + 11'(now_i.minute);

    if (bad_time || on_g == off_g) begin
      lamp_o = 1'b1;
    end else if (on_g < off_g) begin
      lamp_o = (on_g <= now_g) && (now_g < off_g);
    end else begin
      lamp_o = !((off_g <= now_g) && (now_g < on_g));
    end
  end

endmodule

// ----- hdl/yearly_lamp_schedule_switch.sv -----
// ----------------------------------------------------------------------------
// yearly_lamp_schedule_switch
// Yearly per-day lamp schedule held in a table memory, evaluated on command.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one command word.
//   A write word stores the BCD on and off times in one table entry and gives
//   no result. An evaluate word looks up today's entry and gives one result
//   word, the lamp state, on the output channel (out_valid_o / out_stall_i).
//   An evaluate first reads the table memory into a registered read stage;
//   its result is then registered in the output register once that is free.
//   Throughput: one word per cycle while the output is taken; the single
//   table read port and the one-deep result stage set that figure.
//   A stalled result stays in the output register; one more evaluate can
//   wait behind it with its table read done, and only then is the input
//   stalled. Write words and configuration writes take effect at once.
//   Reset clears the control state, sets the lamp state to on and the
//   registers to disabled, month 1, day 1, empty table. The table itself is
//   not cleared and an entry must be written before it is evaluated.
// ----------------------------------------------------------------------------
module yearly_lamp_schedule_switch #(
  parameter int unsigned MAX_DAYS = 366
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [8:0]  cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [8:0]  entry_index_i,
  input  logic [15:0] on_time_bcd_i,
  input  logic [15:0] off_time_bcd_i,
  input  logic [3:0]  now_month_i,
  input  logic [4:0]  now_day_i,
  input  logic [4:0]  now_hour_i,
  input  logic [5:0]  now_minute_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        lamp_on_o
);

  localparam int unsigned AddrW = $clog2(MAX_DAYS);

  typedef enum logic [1:0] {
    ModeForceOn,
    ModeDecide,
    ModeKeep
  } mode_e;

  // configuration
  logic       enable_q;
  logic [3:0] first_month_q;
  logic [4:0] start_day_q;
  logic [8:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      first_month_q <= 4'd1;
      start_day_q   <= 5'd1;
      total_q       <= 9'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ylss_pkg::CfgEnable:     enable_q      <= cfg_wdata_i[0];
        ylss_pkg::CfgStartMonth: first_month_q <= cfg_wdata_i[3:0];
        ylss_pkg::CfgStartDay:   start_day_q   <= cfg_wdata_i[4:0];
        ylss_pkg::CfgTotalDays:  total_q       <= cfg_wdata_i;
        default:                 enable_q      <= enable_q;
      endcase
    end
  end

  // handshake
  logic out_valid_q;
  logic pend_q;
  logic out_free;
  logic resolve;
  logic accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign resolve    = pend_q && out_free;
  assign in_stall_o = pend_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // lookup of today's entry
  logic        sched_ok;
  logic [8:0]  d0;
  logic [9:0]  last;
  logic        today_ok;
  logic [8:0]  today;
  logic        match;
  logic [8:0]  idx;
  mode_e       mode_d;

  always_comb begin
    sched_ok = enable_q && (total_q != 9'd0) && (total_q <= 9'(MAX_DAYS)) &&
               (first_month_q >= 4'd1) && (first_month_q <= 4'd12) &&
               (start_day_q != 5'd0);
    d0       = ylss_pkg::month_start(first_month_q) + 9'(start_day_q);
    last     = 10'(d0) + 10'(total_q) - 10'd1;
    today_ok = (now_month_i >= 4'd1) && (now_month_i <= 4'd12) && (now_day_i != 5'd0) &&
               (now_day_i <= ylss_pkg::month_len(now_month_i));
    today    = ylss_pkg::month_start(now_month_i) + 9'(now_day_i);
    match    = today_ok && (today >= d0) && (10'(today) <= last);
    idx      = today - d0;

    if (!sched_ok) begin
      mode_d = ModeForceOn;
    end else if (match) begin
      mode_d = (idx < 9'(MAX_DAYS)) ? ModeDecide : ModeKeep;
    end else if (last > 10'(ylss_pkg::YearDays)) begin
      mode_d = ModeForceOn;
    end else begin
      mode_d = ModeKeep;
    end
  end

  // table memory
  logic [31:0] day_table_q [MAX_DAYS];
  logic [31:0] rd_q;
  logic        wr_en;
  logic        rd_en;

  assign wr_en = accept && (command_i == ylss_pkg::CmdWrite) &&
                 (entry_index_i < 9'(MAX_DAYS));
  assign rd_en = accept && (command_i == ylss_pkg::CmdEval) && (mode_d == ModeDecide);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      day_table_q[entry_index_i[AddrW-1:0]] <= {on_time_bcd_i, off_time_bcd_i};
    end
    if (rd_en) begin
      rd_q <= day_table_q[idx[AddrW-1:0]];
    end
  end

  // pending evaluate
  mode_e            mode_q;
  ylss_pkg::clock_t now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (accept && command_i == ylss_pkg::CmdEval) begin
      pend_q <= 1'b1;
    end else if (resolve) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && command_i == ylss_pkg::CmdEval) begin
      mode_q       <= mode_d;
      now_q.hour   <= now_hour_i;
      now_q.minute <= now_minute_i;
    end
  end

  // decision and switch state
  logic decide_lamp;
  logic state_q;
  logic state_d;
  logic lamp_q;

  ylss_decide u_decide (
    .entry_i (rd_q),
    .now_i   (now_q),
    .lamp_o  (decide_lamp)
  );

  always_comb begin
    case (mode_q)
      ModeForceOn: state_d = 1'b1;
      ModeDecide:  state_d = decide_lamp;
      default:     state_d = state_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (resolve) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (resolve) begin
      lamp_q <= state_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign lamp_on_o   = lamp_q;

`ifndef SYNTH
  a_result_is_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resolve |=> out_valid_o && (lamp_on_o == state_q))
    else $error("result word differs from switch state");

  a_force_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resolve && (mode_q == ModeForceOn) |=> lamp_on_o)
    else $error("forced on evaluate gave lamp off");

  a_keep_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resolve && (mode_q == ModeKeep) |=> $stable(state_q))
    else $error("uncovered day changed switch state");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (command_i == ylss_pkg::CmdWrite) && !pend_q |=> !pend_q)
    else $error("write word started an evaluate");

  a_stall_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && out_valid_o && out_stall_i |=> pend_q)
    else $error("pending evaluate lost while output stalled");
`endif

endmodule
